// File: src/flash_upload_word_packer_macros.svh
`ifndef FLASH_UPLOAD_WORD_PACKER_MACROS_SVH
`define FLASH_UPLOAD_WORD_PACKER_MACROS_SVH

// Plain property check, held off while in reset.
`define FUWP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Next-cycle implication, held off while in reset.
`define FUWP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fuwp_pkg.sv
package fuwp_pkg;

	localparam int unsigned PAGE_BYTES_DEF       = 1024;
	localparam int unsigned MIN_UPLOAD_BYTES_DEF = 224;

	localparam logic [1:0] CMD_BEGIN    = 2'd0;
	localparam logic [1:0] CMD_DATA     = 2'd1;
	localparam logic [1:0] CMD_COMPLETE = 2'd2;
	localparam logic [1:0] CMD_ABORT    = 2'd3;

	localparam logic [2:0] OP_ERASE    = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_VECTOR   = 3'd2;
	localparam logic [2:0] OP_ACCEPTED = 3'd3;
	localparam logic [2:0] OP_REJECTED = 3'd4;
	localparam logic [2:0] OP_HALT     = 3'd5;

	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] target_address;
		logic [31:0] word_data;
		logic [2:0]  byte_count;
		logic [5:0]  vector_index;
		logic [31:0] code_length;
	} result_t;

	// Results caused by one request, slot 0 first; n is how many are used.
	typedef struct packed {
		logic [1:0]                    n;
		result_t [MAX_RESULTS-1:0]     r;
	} bundle_t;

	function automatic logic is_vector_slot(input logic [29:0] slot);
		logic hi_zero;
		logic hit;
		hi_zero = (slot[29:6] == 24'd0);
		unique case (slot[5:0])
			6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd14, 6'd15, 6'd28, 6'd56: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hi_zero && hit;
	endfunction

endpackage

// File: src/fuwp_if.sv
interface fuwp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

interface fuwp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] target_address;
	logic [31:0] word_data;
	logic [2:0]  byte_count;
	logic [5:0]  vector_index;
	logic [31:0] code_length;
	logic        last;
	modport source (output valid, operation, target_address, word_data, byte_count,
		vector_index, code_length, last, input ready);
	modport sink (input valid, operation, target_address, word_data, byte_count,
		vector_index, code_length, last, output ready);
endinterface

interface fuwp_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/fuwp_core.sv
module fuwp_core
	import fuwp_pkg::*;
#(
	parameter int unsigned PAGE_BYTES       = PAGE_BYTES_DEF,
	parameter int unsigned MIN_UPLOAD_BYTES = MIN_UPLOAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fuwp_cmd_if.sink   cmd,
	fuwp_cfg_if.sink   cfg,
	input  logic       load_ok,
	output logic       bundle_valid,
	output bundle_t    bundle
);

	// PAGE_BYTES is a power of two, so the page offset is a mask
	localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
	localparam logic [32:0] MIN_LEN   = 33'(MIN_UPLOAD_BYTES);

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  byte_s1;

	logic [31:0] base_q, limit_q;
	logic [31:0] wa_q, pb_q;
	logic [2:0]  pc_q;

	logic        adv;
	logic [1:0]  c;
	logic [31:0] pb_new;
	logic [2:0]  pc_new;
	logic        do_flush;
	logic [2:0]  fl_cnt;
	logic [31:0] fl_data;
	logic        below, over, in_region, erase, vec;
	logic [31:0] offset;
	logic [31:0] wa_fl, wa_after;
	logic        reject;
	logic [1:0]  k;
	bundle_t     b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_BASE) base_q <= cfg.data;
			else limit_q <= cfg.data;
		end
	end

	assign adv       = valid_s1 && ((b.n == 2'd0) || load_ok);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1  <= cmd.command;
			byte_s1 <= cmd.data_byte;
		end
	end

	assign c      = pc_q[1:0];
	assign pb_new = pb_q | ({24'd0, byte_s1} << {c, 3'b000});
	assign pc_new = {1'b0, c} + 3'd1;

	always_comb begin
		if (cmd_s1 == CMD_DATA) begin
			do_flush = (pc_new == 3'd4);
			fl_cnt   = pc_new;
			fl_data  = pb_new;
		end else begin
			do_flush = (cmd_s1 == CMD_COMPLETE) && (pc_q != 3'd0);
			fl_cnt   = pc_q;
			fl_data  = pb_q;
		end
	end

	assign below     = wa_q < base_q;
	assign over      = !below && (wa_q >= limit_q);
	assign in_region = !below && !over;
	assign erase     = (wa_q & PAGE_MASK) == 32'd0;
	assign offset    = wa_q - base_q;
	assign vec       = is_vector_slot(offset[31:2]);

	always_comb begin
		if (over) wa_fl = '0;
		else if (in_region) wa_fl = wa_q + {29'd0, fl_cnt};
		else wa_fl = wa_q;
	end

	assign wa_after = do_flush ? wa_fl : wa_q;
	assign reject   = {1'b0, wa_after} < ({1'b0, base_q} + MIN_LEN);

	// Results are appended in order; unused fields stay zero.
	always_comb begin
		b = '0;
		k = 2'd0;
		unique case (cmd_s1)
			CMD_BEGIN: begin
				b.r[0].operation = OP_HALT;
				k = 2'd1;
			end
			CMD_ABORT: begin
				b.r[0].operation = OP_REJECTED;
				k = 2'd1;
			end
			CMD_DATA, CMD_COMPLETE: begin
				if (do_flush && in_region) begin
					if (erase) begin
						b.r[k].operation      = OP_ERASE;
						b.r[k].target_address = wa_q;
						k = k + 2'd1;
					end
					b.r[k].target_address = wa_q;
					if (vec) begin
						b.r[k].operation    = OP_VECTOR;
						b.r[k].byte_count   = 3'd4;
						b.r[k].vector_index = offset[7:2];
					end else begin
						b.r[k].operation  = OP_WRITE;
						b.r[k].word_data  = fl_data;
						b.r[k].byte_count = fl_cnt;
					end
					k = k + 2'd1;
				end
				if (cmd_s1 == CMD_COMPLETE) begin
					if (reject) begin
						b.r[k].operation = OP_REJECTED;
					end else begin
						b.r[k].operation   = OP_ACCEPTED;
						b.r[k].code_length = wa_after - base_q;
					end
					k = k + 2'd1;
				end
			end
			default: k = 2'd0;
		endcase
		b.n = k;
	end

	assign bundle       = b;
	assign bundle_valid = valid_s1 && (b.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
		end else if (adv) begin
			unique case (cmd_s1)
				CMD_BEGIN: begin
					wa_q <= base_q;
					pb_q <= '0;
					pc_q <= '0;
				end
				CMD_DATA, CMD_COMPLETE: begin
					if (do_flush) begin
						wa_q <= wa_fl;
						pb_q <= '0;
						pc_q <= '0;
					end else if (cmd_s1 == CMD_DATA) begin
						pb_q <= pb_new;
						pc_q <= pc_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/fuwp_emit.sv
`include "flash_upload_word_packer_macros.svh"

module fuwp_emit
	import fuwp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       bundle_valid,
	input  bundle_t    bundle,
	output logic       load_ok,
	fuwp_res_if.source res
);

	logic                        bv_q;
	logic [1:0]                  idx_q;
	logic [1:0]                  cnt_q;
	result_t [MAX_RESULTS-1:0]   slots_q;

	logic    hs, last, load;
	result_t cur;

	assign hs      = bv_q && res.ready;
	assign last    = (idx_q == (cnt_q - 2'd1));
	assign load_ok = !bv_q || (hs && last);
	assign load    = bundle_valid && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q  <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
		end else if (load) begin
			bv_q  <= 1'b1;
			idx_q <= '0;
			cnt_q <= bundle.n;
		end else if (hs) begin
			if (last) bv_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) slots_q <= bundle.r;
	end

	assign cur                = slots_q[idx_q];
	assign res.valid          = bv_q;
	assign res.operation      = cur.operation;
	assign res.target_address = cur.target_address;
	assign res.word_data      = cur.word_data;
	assign res.byte_count     = cur.byte_count;
	assign res.vector_index   = cur.vector_index;
	assign res.code_length    = cur.code_length;
	assign res.last           = last;

	`FUWP_ASSERT(a_idx_in_range, clk, arst_n, !bv_q || (idx_q < cnt_q), "result index past count")
	`FUWP_ASSERT(a_cnt_nonzero, clk, arst_n, !bv_q || (cnt_q != 2'd0), "empty result bundle held")
	`FUWP_ASSERT_NEXT(a_drain, clk, arst_n, hs && last && !load, !bv_q, "bundle not freed after last")

endmodule

// File: src/flash_upload_word_packer.sv
// Channel | Dir | Moves
// cmd     | in  | one request: command, data_byte
// cfg     | in  | register write: index (0 region_base, 1 region_limit), data
// res     | out | one result: operation, address, data, counts, last
//
// A request waits in the input register until the output buffer can take
// its results (0 to 3); they are loaded together and leave one per cycle
// while res is ready. Data bytes that finish no word make no results and
// are taken back to back. The buffer is held until all results have left.
// Reset clears the region registers, write address and pending word.
// A stall on res holds the buffer; cmd stalls while the input register waits.
module flash_upload_word_packer
	import fuwp_pkg::*;
#(
	parameter int unsigned PAGE_BYTES       = PAGE_BYTES_DEF,
	parameter int unsigned MIN_UPLOAD_BYTES = MIN_UPLOAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fuwp_cmd_if.sink   cmd,
	fuwp_cfg_if.sink   cfg,
	fuwp_res_if.source res
);

	logic    load_ok;
	logic    bundle_valid;
	bundle_t bundle;

	fuwp_core #(
		.PAGE_BYTES       (PAGE_BYTES),
		.MIN_UPLOAD_BYTES (MIN_UPLOAD_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.load_ok      (load_ok),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	fuwp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.load_ok      (load_ok),
		.res          (res)
	);

endmodule
